// File: design/qpack_static_field_section_parser_defines.svh
// Assertion macros used by the parser top module.
`ifndef QPACK_STATIC_FIELD_SECTION_PARSER_DEFINES_SVH
`define QPACK_STATIC_FIELD_SECTION_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define QP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define QP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QP_ASSERT_IMPL(lbl, ante, cons, msg)
`define QP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/qpack_pkg.sv
package qpack_pkg;

    localparam int LEN_WIDTH      = 32;
    localparam int STATIC_ENTRIES = 99;
    localparam int MAX_RESULTS    = 3;
    localparam int RQ_DEPTH       = 8;
    localparam int RQ_PTR_W       = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W       = $clog2(RQ_DEPTH + 1);
    localparam int SET_CNT_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        KIND_INDEXED  = 3'd0,
        KIND_NAME_REF = 3'd1,
        KIND_NAME     = 3'd2,
        KIND_VALUE    = 3'd3,
        KIND_LINE_END = 3'd4,
        KIND_DONE     = 3'd5,
        KIND_ERROR    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_PREFIX    = 3'd2,
        ERR_DYNAMIC   = 3'd3,
        ERR_RANGE     = 3'd4,
        ERR_OVERFLOW  = 3'd5
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  table_index;
        logic [7:0]  text_byte;
        logic        huffman_coded;
        t_err        error_code;
        logic        last_result;
    } t_result;

    // Results caused by one byte, item[0] first.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] item;
        logic [SET_CNT_W-1:0]      count;
    } t_result_set;

endpackage

// File: design/qpack_decode.sv
module qpack_byte_parser import qpack_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_eos,
    output t_result_set o_set
);

    typedef enum logic [3:0] {
        PH_RIC, PH_RIC_MORE, PH_DB, PH_DB_MORE, PH_LINE, PH_IDX_MORE,
        PH_NLEN_MORE, PH_NAME, PH_VLEN, PH_VLEN_MORE, PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        FORM_INDEXED, FORM_NAME_REF, FORM_LITERAL
    } t_form;

    localparam int SW = LEN_WIDTH + 7;

    t_phase               r_phase, n_phase;
    logic [LEN_WIDTH-1:0] r_acc, n_acc;
    logic [5:0]           r_shift, n_shift;
    t_form                r_form, n_form;
    logic [LEN_WIDTH-1:0] r_rem, n_rem;
    logic                 r_huff, n_huff;
    logic                 r_drop, n_drop;

    logic [SW-1:0]        w_wide;
    logic [LEN_WIDTH:0]   w_sum;
    logic                 w_ovf;
    logic [6:0]           w_shift_sum;
    logic [5:0]           w_shift_next;

    t_result [MAX_RESULTS-1:0] w_res;
    logic [SET_CNT_W-1:0]      w_cnt;
    logic                      w_done;
    logic                      w_clr;
    t_err                      w_err;

    function automatic t_result mk(t_kind k, logic [6:0] idx, logic [7:0] t, logic h,
                                   t_err e);
        t_result r;
        r.kind          = k;
        r.table_index   = idx;
        r.text_byte     = t;
        r.huffman_coded = h;
        r.error_code    = e;
        r.last_result   = 1'b0;
        return r;
    endfunction

    // Continuation byte of a prefix integer.
    always_comb begin
        w_wide       = SW'(i_byte[6:0]) << r_shift;
        w_sum        = {1'b0, r_acc} + {1'b0, w_wide[LEN_WIDTH-1:0]};
        w_ovf        = (i_byte[6:0] != 7'd0) &&
                       ((r_shift >= 6'(LEN_WIDTH)) || (|w_wide[SW-1:LEN_WIDTH]) ||
                        w_sum[LEN_WIDTH]);
        w_shift_sum  = {1'b0, r_shift} + 7'd7;
        w_shift_next = (w_shift_sum > 7'd63) ? 6'd63 : w_shift_sum[5:0];
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_shift = r_shift;
        n_form  = r_form;
        n_rem   = r_rem;
        n_huff  = r_huff;
        n_drop  = r_drop;
        w_res   = '0;
        w_cnt   = '0;
        w_done  = 1'b0;
        w_clr   = 1'b0;
        w_err   = ERR_NONE;

        if (r_drop) begin
            w_clr = i_eos;
        end else begin
            case (r_phase)
                PH_RIC: begin
                    n_acc   = LEN_WIDTH'(i_byte);
                    n_shift = '0;
                    w_done  = i_byte != 8'hFF;
                    if (!w_done) n_phase = PH_RIC_MORE;
                end
                PH_DB: begin
                    n_acc   = LEN_WIDTH'(i_byte[6:0]);
                    n_shift = '0;
                    w_done  = i_byte[6:0] != 7'h7F;
                    if (!w_done) n_phase = PH_DB_MORE;
                end
                PH_RIC_MORE, PH_DB_MORE, PH_IDX_MORE, PH_NLEN_MORE, PH_VLEN_MORE: begin
                    if (w_ovf) begin
                        w_err = ERR_OVERFLOW;
                    end else begin
                        n_acc  = w_sum[LEN_WIDTH-1:0];
                        w_done = !i_byte[7];
                        if (i_byte[7]) n_shift = w_shift_next;
                    end
                end
                PH_LINE: begin
                    if (i_byte[7]) begin
                        if (!i_byte[6]) begin
                            w_err = ERR_DYNAMIC;
                        end else begin
                            n_form  = FORM_INDEXED;
                            n_phase = PH_IDX_MORE;
                            n_acc   = LEN_WIDTH'(i_byte[5:0]);
                            n_shift = '0;
                            w_done  = i_byte[5:0] != 6'h3F;
                        end
                    end else if (i_byte[6]) begin
                        if (!i_byte[4]) begin
                            w_err = ERR_DYNAMIC;
                        end else begin
                            n_form  = FORM_NAME_REF;
                            n_phase = PH_IDX_MORE;
                            n_acc   = LEN_WIDTH'(i_byte[3:0]);
                            n_shift = '0;
                            w_done  = i_byte[3:0] != 4'hF;
                        end
                    end else if (i_byte[5]) begin
                        n_form  = FORM_LITERAL;
                        n_huff  = i_byte[3];
                        n_phase = PH_NLEN_MORE;
                        n_acc   = LEN_WIDTH'(i_byte[2:0]);
                        n_shift = '0;
                        w_done  = i_byte[2:0] != 3'h7;
                    end else begin
                        w_err = ERR_DYNAMIC;
                    end
                end
                PH_NAME: begin
                    w_res[w_cnt] = mk(KIND_NAME, 7'd0, i_byte, r_huff, ERR_NONE);
                    w_cnt        = w_cnt + 1'b1;
                    n_rem        = r_rem - 1'b1;
                    if (n_rem == '0) n_phase = PH_VLEN;
                end
                PH_VLEN: begin
                    n_huff  = i_byte[7];
                    n_phase = PH_VLEN_MORE;
                    n_acc   = LEN_WIDTH'(i_byte[6:0]);
                    n_shift = '0;
                    w_done  = i_byte[6:0] != 7'h7F;
                end
                PH_VALUE: begin
                    w_res[w_cnt] = mk(KIND_VALUE, 7'd0, i_byte, r_huff, ERR_NONE);
                    w_cnt        = w_cnt + 1'b1;
                    n_rem        = r_rem - 1'b1;
                    if (n_rem == '0) begin
                        w_res[w_cnt] = mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE);
                        w_cnt        = w_cnt + 1'b1;
                        n_phase      = PH_LINE;
                    end
                end
                default: begin
                    // Unused phase code: restart as after reset.
                    n_phase = PH_RIC;
                    n_acc   = '0;
                    n_shift = '0;
                    n_form  = FORM_INDEXED;
                    n_rem   = '0;
                    n_huff  = 1'b0;
                    n_drop  = 1'b0;
                end
            endcase

            if (w_done && w_err == ERR_NONE) begin
                case (n_phase)
                    PH_RIC, PH_RIC_MORE: begin
                        if (n_acc != '0) w_err = ERR_PREFIX;
                        else n_phase = PH_DB;
                    end
                    PH_DB, PH_DB_MORE: begin
                        if (n_acc != '0) w_err = ERR_PREFIX;
                        else n_phase = PH_LINE;
                    end
                    PH_IDX_MORE: begin
                        if (n_acc >= LEN_WIDTH'(STATIC_ENTRIES)) begin
                            w_err = ERR_RANGE;
                        end else if (r_form == FORM_INDEXED && n_form == FORM_INDEXED) begin
                            w_res[w_cnt] = mk(KIND_INDEXED, n_acc[6:0], 8'd0, 1'b0,
                                              ERR_NONE);
                            w_cnt        = w_cnt + 1'b1;
                            w_res[w_cnt] = mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE);
                            w_cnt        = w_cnt + 1'b1;
                            n_phase      = PH_LINE;
                        end else if (n_form == FORM_INDEXED) begin
                            w_res[w_cnt] = mk(KIND_INDEXED, n_acc[6:0], 8'd0, 1'b0,
                                              ERR_NONE);
                            w_cnt        = w_cnt + 1'b1;
                            w_res[w_cnt] = mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE);
                            w_cnt        = w_cnt + 1'b1;
                            n_phase      = PH_LINE;
                        end else begin
                            w_res[w_cnt] = mk(KIND_NAME_REF, n_acc[6:0], 8'd0, 1'b0,
                                              ERR_NONE);
                            w_cnt        = w_cnt + 1'b1;
                            n_phase      = PH_VLEN;
                        end
                    end
                    PH_NLEN_MORE: begin
                        n_rem   = n_acc;
                        n_phase = (n_acc == '0) ? PH_VLEN : PH_NAME;
                    end
                    PH_VLEN_MORE: begin
                        n_rem = n_acc;
                        if (n_acc == '0) begin
                            w_res[w_cnt] = mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE);
                            w_cnt        = w_cnt + 1'b1;
                            n_phase      = PH_LINE;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end
                    default: ;
                endcase
            end

            if (w_err != ERR_NONE) begin
                w_res[w_cnt] = mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, w_err);
                w_cnt        = w_cnt + 1'b1;
                if (i_eos) w_clr = 1'b1;
                else n_drop = 1'b1;
            end else if (i_eos) begin
                if (n_phase == PH_LINE)
                    w_res[w_cnt] = mk(KIND_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE);
                else
                    w_res[w_cnt] = mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED);
                w_cnt = w_cnt + 1'b1;
                w_clr = 1'b1;
            end

            if (w_cnt != '0) w_res[w_cnt - 1'b1].last_result = 1'b1;
        end

        if (w_clr) begin
            n_phase = PH_RIC;
            n_acc   = '0;
            n_shift = '0;
            n_form  = FORM_INDEXED;
            n_rem   = '0;
            n_huff  = 1'b0;
            n_drop  = 1'b0;
        end

        o_set.item  = w_res;
        o_set.count = i_accept ? w_cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIC;
            r_acc   <= '0;
            r_shift <= '0;
            r_form  <= FORM_INDEXED;
            r_rem   <= '0;
            r_huff  <= 1'b0;
            r_drop  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_shift <= n_shift;
            r_form  <= n_form;
            r_rem   <= n_rem;
            r_huff  <= n_huff;
            r_drop  <= n_drop;
        end
    end

endmodule

// File: design/qpack_result_fifo.sv
module qpack_result_fifo import qpack_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_result_set         i_set,
    input  logic                i_pop,
    output t_result             o_head,
    output logic                o_valid,
    output logic [RQ_CNT_W-1:0] o_count
);

    t_result               r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wp;
    logic [RQ_PTR_W-1:0]   r_rp;
    logic [RQ_CNT_W-1:0]   r_count;
    logic                  w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    // Store up to three results of one byte in order.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (SET_CNT_W'(k) < i_set.count)
                r_mem[r_wp + RQ_PTR_W'(k)] <= i_set.item[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + RQ_PTR_W'(i_set.count);
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_count <= r_count + RQ_CNT_W'(i_set.count) - RQ_CNT_W'(w_pop);
        end
    end

endmodule

// File: design/qpack_static_field_section_parser.sv
// Channel   Direction  tdata                          tuser     tlast
// s_axis    in         [7:0] data_byte                -         end_of_section
// m_axis    out        [6:0] table_index, [14:7]      [2:0]     last_result
//                      text_byte, [15] huffman_coded,  kind
//                      [18:16] error_code
//
// One input byte is parsed in the cycle it is accepted; up to one byte per cycle while s_axis tready is high.
// Its results are written into the result queue at the accepting edge and offered on m_axis in order.
// Each byte yields zero to three results, which drain one per cycle, while m_axis tready
// is high, from an 8-entry result queue; input tready drops while fewer than three slots are free.
// Reset is synchronous, active low, clears parser state and the queue, holds tready low.
// Output stalls only back up the queue; the parser keeps its state between bytes.
`include "qpack_static_field_section_parser_defines.svh"

module qpack_static_field_section_parser import qpack_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // table_index, text_byte, huffman_coded, error_code
    output logic [2:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast
);

    t_result_set         w_set;
    t_result             w_head;
    logic [RQ_CNT_W-1:0] w_count;
    logic                w_accept;
    logic                w_out_err;
    logic                w_out_other;

    assign o_s_axis_tready = i_rst_n && (w_count <= RQ_CNT_W'(RQ_DEPTH - MAX_RESULTS));
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    qpack_byte_parser u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_eos    (i_s_axis_tlast),
        .o_set    (w_set)
    );

    qpack_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_set   (w_set),
        .i_pop   (i_m_axis_tready),
        .o_head  (w_head),
        .o_valid (o_m_axis_tvalid),
        .o_count (w_count)
    );

    assign o_m_axis_tdata = {5'd0, w_head.error_code, w_head.huffman_coded,
                             w_head.text_byte, w_head.table_index};
    assign o_m_axis_tuser = w_head.kind;
    assign o_m_axis_tlast = w_head.last_result;

    assign w_out_err   = o_m_axis_tvalid && (w_head.kind == KIND_ERROR);
    assign w_out_other = o_m_axis_tvalid && (w_head.kind != KIND_ERROR);

    `QP_ASSERT_IMPL(a_no_push_idle, !w_accept, w_set.count == '0, "results without a byte")
    `QP_ASSERT_IMPL(a_room, 1'b1, w_count <= RQ_CNT_W'(RQ_DEPTH), "queue overrun")
    `QP_ASSERT_IMPL(a_err_code, w_out_err, w_head.error_code != ERR_NONE, "error without code")
    `QP_ASSERT_IMPL(a_no_code, w_out_other, w_head.error_code == ERR_NONE, "code on non-error")

endmodule

// File: test/tb_top.sv
module tb_top;
    import qpack_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 430;
    localparam int DRAIN_CYCLES = 24;

    // Parser phases, one per position in the encoded section
    typedef enum logic [3:0] {
        P_INSERT_COUNT,
        P_INSERT_COUNT_CONT,
        P_BASE,
        P_BASE_CONT,
        P_LINE_START,
        P_INDEX_CONT,
        P_NAME_LEN_CONT,
        P_NAME_BYTES,
        P_VALUE_LEN,
        P_VALUE_LEN_CONT,
        P_VALUE_BYTES
    } t_phase;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_section_byte;

    typedef struct {
        logic [7:0] data;
        logic       eos;
        bit         typed;
        int         n;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = 8'h00;
    logic        s_last   = 1'b0;
    logic        m_ready  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Predictor state
    t_phase          phase;
    longint unsigned int_acc;
    int              int_shift;
    int              form;
    longint unsigned str_left;
    logic            str_huff;
    bit              dropping;

    longint unsigned str_left_hint;

    t_result         byte_results[$];
    t_result         pending_tokens[$];
    t_section_byte   section_bytes[$];
    t_directed_row   directed_rows[$];

    int fault_cnt  = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    qpack_static_field_section_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result mk(t_kind k, logic [6:0] idx, logic [7:0] txt, logic huf,
                                   t_err e, logic last);
        t_result r;
        r.kind          = k;
        r.table_index   = idx;
        r.text_byte     = txt;
        r.huffman_coded = huf;
        r.error_code    = e;
        r.last_result   = last;
        return r;
    endfunction

    function automatic void clear_parser();
        phase     = P_INSERT_COUNT;
        int_acc   = 0;
        int_shift = 0;
        form      = 0;
        str_left  = 0;
        str_huff  = 1'b0;
        dropping  = 1'b0;
    endfunction

    function automatic bit int_start(logic [7:0] b, int nbits);
        longint unsigned mask;
        mask      = (64'd1 << nbits) - 1;
        int_acc   = b & mask;
        int_shift = 0;
        return int_acc < mask;
    endfunction

    // Continuation byte: 0 more to come, 1 complete, -1 overflow
    function automatic int int_cont(logic [7:0] b);
        longint unsigned lim;
        longint unsigned pay;
        longint unsigned add;
        lim = (64'd1 << LEN_WIDTH) - 1;
        pay = b[6:0];
        if (pay != 0) begin
            if (int_shift >= LEN_WIDTH || pay > (lim >> int_shift))
                return -1;
            add = pay << int_shift;
            if (int_acc > lim - add)
                return -1;
            int_acc += add;
        end
        if (!b[7])
            return 1;
        int_shift = (int_shift + 7 > 63) ? 63 : int_shift + 7;
        return 0;
    endfunction

    function automatic void add_result(t_result r);
        byte_results.insert(byte_results.size(), r);
    endfunction

    // Work out the tokens one section byte produces; appends to byte_results
    function automatic void parse_byte(logic [7:0] b, logic eos);
        int              first;
        t_err            err;
        bit              done;
        int              r;
        longint unsigned v;
        first = byte_results.size();
        err   = ERR_NONE;
        done  = 1'b0;
        if (dropping) begin
            if (eos)
                clear_parser();
            return;
        end
        case (phase)
            P_INSERT_COUNT: begin
                done = int_start(b, 8);
                if (!done)
                    phase = P_INSERT_COUNT_CONT;
            end
            P_BASE: begin
                done = int_start(b, 7);
                if (!done)
                    phase = P_BASE_CONT;
            end
            P_INSERT_COUNT_CONT, P_BASE_CONT, P_INDEX_CONT, P_NAME_LEN_CONT,
            P_VALUE_LEN_CONT: begin
                r = int_cont(b);
                if (r < 0)
                    err = ERR_OVERFLOW;
                else
                    done = (r == 1);
            end
            P_LINE_START: begin
                if (b[7]) begin
                    if (!b[6]) begin
                        err = ERR_DYNAMIC;
                    end else begin
                        form  = 0;
                        phase = P_INDEX_CONT;
                        done  = int_start(b, 6);
                    end
                end else if (b[6]) begin
                    if (!b[4]) begin
                        err = ERR_DYNAMIC;
                    end else begin
                        form  = 1;
                        phase = P_INDEX_CONT;
                        done  = int_start(b, 4);
                    end
                end else if (b[5]) begin
                    form     = 2;
                    str_huff = b[3];
                    phase    = P_NAME_LEN_CONT;
                    done     = int_start(b, 3);
                end else begin
                    err = ERR_DYNAMIC;
                end
            end
            P_NAME_BYTES: begin
                add_result(mk(KIND_NAME, 7'd0, b, str_huff, ERR_NONE, 1'b0));
                str_left--;
                if (str_left == 0)
                    phase = P_VALUE_LEN;
            end
            P_VALUE_LEN: begin
                str_huff = b[7];
                phase    = P_VALUE_LEN_CONT;
                done     = int_start(b, 7);
            end
            P_VALUE_BYTES: begin
                add_result(mk(KIND_VALUE, 7'd0, b, str_huff, ERR_NONE, 1'b0));
                str_left--;
                if (str_left == 0) begin
                    add_result(mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b0));
                    phase = P_LINE_START;
                end
            end
            default: clear_parser();
        endcase

        if (done && err == ERR_NONE) begin
            v = int_acc;
            case (phase)
                P_INSERT_COUNT, P_INSERT_COUNT_CONT: begin
                    if (v != 0)
                        err = ERR_PREFIX;
                    else
                        phase = P_BASE;
                end
                P_BASE, P_BASE_CONT: begin
                    if (v != 0)
                        err = ERR_PREFIX;
                    else
                        phase = P_LINE_START;
                end
                P_INDEX_CONT: begin
                    if (v >= STATIC_ENTRIES) begin
                        err = ERR_RANGE;
                    end else if (form == 0) begin
                        add_result(mk(KIND_INDEXED, v[6:0], 8'd0, 1'b0, ERR_NONE, 1'b0));
                        add_result(mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b0));
                        phase = P_LINE_START;
                    end else begin
                        add_result(mk(KIND_NAME_REF, v[6:0], 8'd0, 1'b0, ERR_NONE, 1'b0));
                        phase = P_VALUE_LEN;
                    end
                end
                P_NAME_LEN_CONT: begin
                    str_left = v;
                    phase    = (v == 0) ? P_VALUE_LEN : P_NAME_BYTES;
                end
                P_VALUE_LEN_CONT: begin
                    str_left = v;
                    if (v == 0) begin
                        add_result(mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b0));
                        phase = P_LINE_START;
                    end else begin
                        phase = P_VALUE_BYTES;
                    end
                end
                default: ;
            endcase
        end

        if (err != ERR_NONE) begin
            add_result(mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, err, 1'b0));
            if (eos)
                clear_parser();
            else
                dropping = 1'b1;
        end else if (eos) begin
            if (phase == P_LINE_START)
                add_result(mk(KIND_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b0));
            else
                add_result(mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED, 1'b0));
            clear_parser();
        end

        if (byte_results.size() > first)
            byte_results[byte_results.size() - 1].last_result = 1'b1;
    endfunction

    function automatic void row(logic [7:0] d, logic e);
        t_directed_row x;
        x.data  = d;
        x.eos   = e;
        x.typed = 1'b0;
        x.n     = 0;
        x.r0    = '0;
        x.r1    = '0;
        x.r2    = '0;
        directed_rows.insert(directed_rows.size(), x);
    endfunction

    function automatic void row_typed(logic [7:0] d, logic e, int n, t_result a, t_result b,
                                      t_result c);
        t_directed_row x;
        x.data  = d;
        x.eos   = e;
        x.typed = 1'b1;
        x.n     = n;
        x.r0    = a;
        x.r1    = b;
        x.r2    = c;
        directed_rows.insert(directed_rows.size(), x);
    endfunction

    function automatic void push(logic [7:0] d);
        t_section_byte x;
        x.data = d;
        x.eos  = 1'b0;
        section_bytes.insert(section_bytes.size(), x);
    endfunction

    // Prefix-coded integer; pad adds redundant zero continuation payloads
    function automatic void push_int(logic [7:0] hi, int nbits, longint unsigned v, int pad);
        longint unsigned mask;
        mask = (64'd1 << nbits) - 1;
        if (v < mask) begin
            push(hi | 8'(v));
            return;
        end
        push(hi | 8'(mask));
        v -= mask;
        while (v >= 128) begin
            push(8'h80 | 8'(v & 64'h7F));
            v >>= 7;
        end
        if (pad > 0) begin
            push(8'h80 | 8'(v));
            repeat (pad - 1) push(8'h80);
            push(8'h00);
        end else begin
            push(8'(v));
        end
    endfunction

    function automatic int pick_pad();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 12) : 0;
    endfunction

    function automatic longint unsigned pick_index();
        case ($urandom_range(0, 24))
            0: return $urandom_range(99, 300);
            1: return 64'hFFFF_FFFF;
            2: return 64'h1_0000_0000 + $urandom_range(0, 1000);
            default: return $urandom_range(0, 98);
        endcase
    endfunction

    function automatic longint unsigned pick_len();
        case ($urandom_range(0, 24))
            0: return $urandom_range(120, 140);
            1: return 0;
            2: return 64'h1_0000_0000 + $urandom_range(0, 1000);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic void push_string(longint unsigned len);
        // Overflowing lengths leave nothing to send; the block drops the rest anyway
        if (len > 200)
            return;
        repeat (int'(len)) push(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_string_field(logic [7:0] hi, int nbits);
        str_left_hint = pick_len();
        push_int(hi, nbits, str_left_hint, pick_pad());
        push_string(str_left_hint);
    endfunction

    function automatic void gen_section();
        int            start;
        int            sel;
        int            lines;
        int            cut;
        logic [7:0]    hi;
        start = section_bytes.size();
        sel   = $urandom_range(0, 99);
        if (sel < 12) begin
            if (sel < 6) begin
                push(8'h00);
                push(8'h00);
            end
            repeat ($urandom_range(1, 8)) push(8'($urandom_range(0, 255)));
        end else begin
            if (sel < 16)
                push_int(8'h00, 8, $urandom_range(1, 400), 0);
            else
                push(8'h00);
            hi = {1'($urandom_range(0, 1)), 7'd0};
            if (sel >= 16 && sel < 20)
                push_int(hi, 7, $urandom_range(1, 200), pick_pad());
            else
                push(hi);
            lines = $urandom_range(0, 5);
            repeat (lines) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: push_int(8'hC0, 6, pick_index(), pick_pad());
                    3, 4, 5: begin
                        hi = 8'h50 | {2'b00, 1'($urandom_range(0, 1)), 5'd0};
                        push_int(hi, 4, pick_index(), pick_pad());
                        push_string_field({1'($urandom_range(0, 1)), 7'd0}, 7);
                    end
                    6, 7, 8: begin
                        hi = 8'h20 | {3'b000, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 3'd0};
                        push_string_field(hi, 3);
                        push_string_field({1'($urandom_range(0, 1)), 7'd0}, 7);
                    end
                    default: begin
                        // line starts that point at the dynamic table or past the base
                        case ($urandom_range(0, 3))
                            0: push(8'h80 | 8'($urandom_range(0, 63)));
                            1: push(8'h40 | (8'($urandom_range(0, 255)) & 8'h2F));
                            2: push(8'h10 | 8'($urandom_range(0, 15)));
                            default: push(8'($urandom_range(0, 15)));
                        endcase
                    end
                endcase
            end
            // cut the section short now and then
            if ($urandom_range(0, 6) == 0 && section_bytes.size() - start > 1) begin
                cut = $urandom_range(1, section_bytes.size() - start - 1);
                while (section_bytes.size() > start + cut)
                    void'(section_bytes.pop_back());
            end
        end
        section_bytes[section_bytes.size() - 1].eos = 1'b1;
    endfunction

    task automatic send_byte(logic [7:0] d, logic e, bit typed, int n, t_result [2:0] want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        s_last  <= e;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        burst_left--;
        byte_results.delete();
        parse_byte(d, e);
        if (typed) begin
            for (int i = 0; i < n; i++)
                pending_tokens.insert(pending_tokens.size(), want[i]);
        end else begin
            foreach (byte_results[i])
                pending_tokens.insert(pending_tokens.size(), byte_results[i]);
        end
    endtask

    initial begin : stimulus
        t_directed_row dr;
        t_section_byte sb;
        clear_parser();

        // well-formed section touching each line form and the index extremes
        row(8'h00, 1'b0);
        row(8'h00, 1'b0);
        row_typed(8'hC0, 1'b0, 2, mk(KIND_INDEXED, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b0),
                  mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b1), '0);
        row(8'hFF, 1'b0);
        row_typed(8'h23, 1'b0, 2, mk(KIND_INDEXED, 7'd98, 8'd0, 1'b0, ERR_NONE, 1'b0),
                  mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b1), '0);
        row(8'h5F, 1'b0);
        row_typed(8'h00, 1'b0, 1, mk(KIND_NAME_REF, 7'd15, 8'd0, 1'b0, ERR_NONE, 1'b1), '0, '0);
        row(8'h83, 1'b0);
        row(8'hFF, 1'b0);
        row(8'h00, 1'b0);
        row_typed(8'h41, 1'b0, 2, mk(KIND_VALUE, 7'd0, 8'h41, 1'b1, ERR_NONE, 1'b0),
                  mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b1), '0);
        row(8'h2B, 1'b0);
        row(8'h61, 1'b0);
        row(8'h62, 1'b0);
        row(8'h63, 1'b0);
        row_typed(8'h00, 1'b1, 2, mk(KIND_LINE_END, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b0),
                  mk(KIND_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b1), '0);
        // index one past the table, then the dropped tail
        row(8'h00, 1'b0);
        row(8'h00, 1'b0);
        row(8'hFF, 1'b0);
        row_typed(8'h24, 1'b0, 1, mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, ERR_RANGE, 1'b1), '0, '0);
        row_typed(8'h01, 1'b1, 0, '0, '0, '0);
        // nonzero insert count on a final byte
        row_typed(8'h01, 1'b1, 1, mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, ERR_PREFIX, 1'b1), '0, '0);
        // section ending inside the prefix
        row_typed(8'h00, 1'b1, 1, mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED, 1'b1),
                  '0, '0);
        // empty section
        row(8'h00, 1'b0);
        row_typed(8'h00, 1'b1, 1, mk(KIND_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE, 1'b1), '0, '0);
        // sign bit of the base set, then a name reference into the dynamic table
        row(8'h00, 1'b0);
        row(8'h80, 1'b0);
        row_typed(8'h40, 1'b1, 1, mk(KIND_ERROR, 7'd0, 8'd0, 1'b0, ERR_DYNAMIC, 1'b1), '0, '0);

        while (section_bytes.size() < RANDOM_BYTES)
            gen_section();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            dr = directed_rows[i];
            send_byte(dr.data, dr.eos, dr.typed, dr.n, {dr.r2, dr.r1, dr.r0});
        end
        foreach (section_bytes[i]) begin
            sb = section_bytes[i];
            send_byte(sb.data, sb.eos, 1'b0, 0, '0);
        end
        s_valid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: switch between free flow, light, moderate and heavy stalling
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
        end
        stall_left--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 7) != 0);
            2: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // Compare each output transaction with the oldest expected token
    always @(posedge i_clk) begin : check_out
        t_result seen;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            seen.kind          = t_kind'(o_m_axis_tuser);
            seen.table_index   = o_m_axis_tdata[6:0];
            seen.text_byte     = o_m_axis_tdata[14:7];
            seen.huffman_coded = o_m_axis_tdata[15];
            seen.error_code    = t_err'(o_m_axis_tdata[18:16]);
            seen.last_result   = o_m_axis_tlast;
            if (pending_tokens.size() == 0) begin
                if (fault_cnt < 10)
                    $display("unexpected token: k=%0d i=%0d t=%02h h=%0b e=%0d l=%0b",
                             seen.kind, seen.table_index, seen.text_byte,
                             seen.huffman_coded, seen.error_code, seen.last_result);
                fault_cnt++;
            end else begin
                want = pending_tokens.pop_front();
                if (seen !== want || o_m_axis_tdata[23:19] !== 5'd0) begin
                    if (fault_cnt < 10) begin
                        $display("token mismatch: exp k=%0d i=%0d t=%02h h=%0b e=%0d l=%0b",
                                 want.kind, want.table_index, want.text_byte,
                                 want.huffman_coded, want.error_code, want.last_result);
                        $display("                got k=%0d i=%0d t=%02h h=%0b e=%0d l=%0b pad=%02h",
                                 seen.kind, seen.table_index, seen.text_byte,
                                 seen.huffman_coded, seen.error_code, seen.last_result,
                                 o_m_axis_tdata[23:19]);
                    end
                    fault_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+design
design/qpack_pkg.sv
design/qpack_decode.sv
design/qpack_result_fifo.sv
design/qpack_static_field_section_parser.sv
test/tb_top.sv
